>>> rtl/mte_pkg.sv
// Shared types and constants for the MIDI track event encoder.
// Depends on nothing; imported by mte_frame_build, midi_track_event_encoder and the testbench.
package mte_pkg;

    localparam int FRAME_BYTES = 7;
    localparam int CNT_W       = 3;
    localparam int VLQ_BITS    = 28;
    localparam int VLQ_GROUPS  = 4;
    localparam int TICK_W      = 28;
    localparam int TEMPO_W     = 24;

    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 24'd500000;

    localparam logic [7:0] META_PREFIX = 8'hFF;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] TEMPO_LEN   = 8'h03;
    localparam logic [7:0] VLQ_CONT    = 8'h80;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_EVENT = 2'd1,
        REQ_END   = 2'd2
    } req_kind_t;

    typedef struct packed {
        req_kind_t           req_type;
        logic [TICK_W-1:0]   tick;
        logic [7:0]          event_type;
        logic [3:0]          channel;
        logic [7:0]          data_first;
        logic [7:0]          data_second;
    } item_t;

    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;    // bytes[0] leaves first
        logic [CNT_W-1:0]            count;    // zero for an unused kind
        logic                        tick_we;
    } frame_t;

endpackage

>>> rtl/mte_frame_build.sv
// Builds the byte frame for one item: VLQ delta, status and data, or a meta event.
// Depends on mte_pkg.
module mte_frame_build #(
    parameter int TICK_BITS = 28
) (
    input  mte_pkg::item_t               item,
    input  logic [TICK_BITS-1:0]         prev_tick,
    input  logic [mte_pkg::TEMPO_W-1:0]  tempo,
    output mte_pkg::frame_t              frame,
    output logic [TICK_BITS-1:0]         next_tick
);
    import mte_pkg::*;

    logic [TICK_BITS-1:0] tick_m;
    logic [TICK_BITS-1:0] delta;
    logic [VLQ_BITS-1:0]  delta_ext;
    logic [6:0]           grp [VLQ_GROUPS];
    logic [CNT_W-1:0]     ngrp;
    logic [1:0]           gidx [FRAME_BYTES];
    logic [7:0]           status;

    assign tick_m    = item.tick[TICK_BITS-1:0];
    assign delta     = (tick_m >= prev_tick) ? (tick_m - prev_tick) : '0;
    assign delta_ext = VLQ_BITS'(delta);
    assign status    = item.event_type | {4'h0, item.channel};

    always_comb begin
        for (int g = 0; g < VLQ_GROUPS; g++) begin
            grp[g] = delta_ext[7*g +: 7];
        end
        priority if (grp[3] != 7'd0) ngrp = CNT_W'(4);
        else if (grp[2] != 7'd0)     ngrp = CNT_W'(3);
        else if (grp[1] != 7'd0)     ngrp = CNT_W'(2);
        else                         ngrp = CNT_W'(1);
    end

    always_comb begin
        frame     = '0;
        next_tick = prev_tick;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            gidx[k] = 2'(ngrp - CNT_W'(1) - CNT_W'(k));
        end
        unique case (item.req_type)
            REQ_START: begin
                frame.bytes[0] = 8'h00;
                frame.bytes[1] = META_PREFIX;
                frame.bytes[2] = META_TEMPO;
                frame.bytes[3] = TEMPO_LEN;
                frame.bytes[4] = tempo[23:16];
                frame.bytes[5] = tempo[15:8];
                frame.bytes[6] = tempo[7:0];
                frame.count    = CNT_W'(7);
                frame.tick_we  = 1'b1;
                next_tick      = '0;
            end
            REQ_EVENT: begin
                // Slot k holds a VLQ group, most significant first, then the
                // status and the two data bytes.
                for (int k = 0; k < FRAME_BYTES; k++) begin
                    if (CNT_W'(k) < ngrp) begin
                        frame.bytes[k] = {1'b0, grp[gidx[k]]} |
                                         ((CNT_W'(k) == ngrp - CNT_W'(1)) ? 8'h00 : VLQ_CONT);
                    end else if (CNT_W'(k) == ngrp) begin
                        frame.bytes[k] = status;
                    end else if (CNT_W'(k) == ngrp + CNT_W'(1)) begin
                        frame.bytes[k] = item.data_first;
                    end else if (CNT_W'(k) == ngrp + CNT_W'(2)) begin
                        frame.bytes[k] = item.data_second;
                    end else begin
                        frame.bytes[k] = 8'h00;
                    end
                end
                frame.count   = ngrp + CNT_W'(3);
                frame.tick_we = 1'b1;
                next_tick     = tick_m;
            end
            REQ_END: begin
                frame.bytes[0] = 8'h00;
                frame.bytes[1] = META_PREFIX;
                frame.bytes[2] = META_EOT;
                frame.bytes[3] = 8'h00;
                frame.count    = CNT_W'(4);
            end
            default: begin
                frame.count = '0;
            end
        endcase
    end

endmodule

>>> rtl/midi_track_event_encoder.sv
// Top level of the MIDI track event encoder: input register, byte serializer,
// tempo register and tick state. Depends on mte_pkg and mte_frame_build.
//
// Turns timed items into Standard MIDI File track bytes, one byte per output
// word. A start item (tuser 0) sends 00 FF 51 03 and the three tempo bytes,
// big-endian, and clears the remembered tick. A channel event (tuser 1) sends
// the tick distance to the previous event as a variable-length quantity (zero
// when time runs backwards), then event_type|channel and the two data bytes.
// An end item (tuser 2) sends 00 FF 2F 00. Kind 3 sends nothing. m_tlast marks
// the final byte of each item. Rate: the output moves one byte per cycle
// while m_tready is high; an item has 7 bytes for start, 4 for end and 4 to 7
// for a channel event. The input register captures the accepted word, then
// the serializer loads its frame once it is free and presents the first byte.
// The next item is taken into the input register while the serializer still
// drains, and its frame loads in the cycle the last byte of the previous one
// is taken, so a sustained stream runs without gap cycles on the output.
// Write the tempo with cfg_wr_en only while the block is idle; it is
// sampled at frame load.
module midi_track_event_encoder #(
    parameter int TICK_BITS = 28
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    // [27:0] tick, [35:28] event_type, [39:36] channel,
    // [47:40] data_first, [55:48] data_second
    input  logic [55:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    // result bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]  m_tdata,
    // last_byte
    output logic        m_tlast,
    // tempo register
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data
);
    import mte_pkg::*;

    // input register
    logic                         in_valid_reg;
    item_t                        in_item_reg;
    // serializer: bytes waiting and how many are left
    logic [FRAME_BYTES-1:0][7:0]  bytes_reg;
    logic [CNT_W-1:0]             cnt_reg;
    // state and configuration
    logic [TICK_BITS-1:0]         prev_tick_reg;
    logic [TEMPO_W-1:0]           tempo_reg;

    frame_t                       frame;
    logic [TICK_BITS-1:0]         next_tick;
    logic                         out_take;
    logic                         ser_free;
    logic                         consume;
    logic                         s_take;
    item_t                        s_item;

    // unpack the input word
    assign s_item.req_type    = req_kind_t'(s_tuser);
    assign s_item.tick        = s_tdata[27:0];
    assign s_item.event_type  = s_tdata[35:28];
    assign s_item.channel     = s_tdata[39:36];
    assign s_item.data_first  = s_tdata[47:40];
    assign s_item.data_second = s_tdata[55:48];

    mte_frame_build #(
        .TICK_BITS (TICK_BITS)
    ) u_build (
        .item      (in_item_reg),
        .prev_tick (prev_tick_reg),
        .tempo     (tempo_reg),
        .frame     (frame),
        .next_tick (next_tick)
    );

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = bytes_reg[0];
    assign m_tlast  = (cnt_reg == CNT_W'(1));
    assign out_take = m_tvalid && m_tready;

    // serializer can take a new frame when empty or on its final byte
    assign ser_free = (cnt_reg == '0) || (m_tlast && m_tready);
    assign consume  = in_valid_reg && ser_free;
    assign s_tready = !in_valid_reg || consume;
    assign s_take   = s_tvalid && s_tready;

    // hold the tempo and input item; advance the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            tempo_reg    <= TEMPO_RESET;
        end else begin
            if (cfg_wr_en) begin
                tempo_reg <= cfg_wr_data;
            end
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_item;
        end
    end

    // load a frame, or shift out one byte per taken word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            prev_tick_reg <= '0;
        end else begin
            if (consume) begin
                cnt_reg <= frame.count;
                if (frame.tick_we) begin
                    prev_tick_reg <= next_tick;
                end
            end else if (out_take) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            bytes_reg <= frame.bytes;
        end else if (out_take) begin
            bytes_reg <= bytes_reg >> 8;
        end
    end

endmodule

>>> test/tb_midi_track_event_encoder.sv
`timescale 1ns / 100ps
// Testbench for midi_track_event_encoder: directed table plus random track sequences,
// every output word checked against a local byte-stream predictor or typed-in bytes.
// Depends on mte_pkg and the encoder RTL; reads no files.
module tb_midi_track_event_encoder;
    import mte_pkg::*;

    localparam logic [1:0] REQ_UNUSED    = 2'd3;   // kind that the block ignores
    localparam logic [7:0] DELTA_NONE    = 8'h00;  // zero delta ahead of a meta event
    localparam logic [7:0] EOT_LEN       = 8'h00;  // length byte of end of track
    localparam logic [3:0] USE_PREDICTOR = 4'hF;   // row has no typed-in bytes
    localparam int         SETTLE_CYCLES = 8;
    localparam int         TAIL_CYCLES   = 20;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         PHASE_ITEMS   = 20;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TICK_W-1:0] tick;
        logic [7:0]        event_type;
        logic [3:0]        channel;
        logic [7:0]        data_first;
        logic [7:0]        data_second;
        logic [3:0]        typed_count;
        logic [0:6][7:0]   typed_bytes;
    } track_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } track_byte_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [23:0] cfg_wr_data = '0;

    // predictor state
    logic [TEMPO_W-1:0] tempo_model     = TEMPO_RESET;
    logic [TICK_W-1:0]  last_event_tick = '0;

    track_byte_t   pending_bytes[$];
    track_item_t   directed_rows[$];
    int            mismatch_count = 0;
    int            bytes_checked  = 0;
    int            items_accepted = 0;
    int            tempo_writes   = 0;
    int            sink_stall_pct = 0;
    int unsigned   cycle_count    = 0;

    midi_track_event_encoder u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    // Give up on a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, pending_bytes.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Sink side: stall at the rate the current phase asks for.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 30)
            $display("MISMATCH at output byte %0d: %s", bytes_checked, what);
        mismatch_count++;
    endtask

    // Compare each accepted output word with the oldest expected byte.
    always @(posedge aclk) begin : byte_check
        track_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.value)
                    report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, want.value));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_byte %0b, want %0b", m_tlast, want.last));
            end
            bytes_checked++;
        end
    end

    // Encode one item into track bytes and advance the tick state.
    function automatic int encode_item(input track_item_t it, output logic [0:6][7:0] frame);
        int                 n;
        int                 groups;
        logic [TICK_W-1:0]  delta;
        n     = 0;
        frame = '0;
        if (it.kind == REQ_START) begin
            last_event_tick = '0;
            frame = {DELTA_NONE, META_PREFIX, META_TEMPO, TEMPO_LEN, tempo_model};
            n     = 7;
        end else if (it.kind == REQ_EVENT) begin
            // Time running backwards collapses to a zero delta.
            delta  = (it.tick >= last_event_tick) ? it.tick - last_event_tick : '0;
            last_event_tick = it.tick;
            groups = 1;
            while (groups < VLQ_GROUPS && (delta >> (7 * groups)) != 0)
                groups++;
            for (int g = groups - 1; g >= 0; g--) begin
                frame[n] = {1'b0, delta[7 * g +: 7]} | ((g != 0) ? VLQ_CONT : 8'h00);
                n++;
            end
            frame[n]     = it.event_type | {4'h0, it.channel};
            frame[n + 1] = it.data_first;
            frame[n + 2] = it.data_second;
            n += 3;
        end else if (it.kind == REQ_END) begin
            frame[0:3] = {DELTA_NONE, META_PREFIX, META_EOT, EOT_LEN};
            n          = 4;
        end
        return n;
    endfunction

    function automatic track_item_t mk_item(input logic [1:0] kind, input logic [27:0] tick,
                                            input logic [7:0] ev, input logic [3:0] ch,
                                            input logic [7:0] d1, input logic [7:0] d2,
                                            input logic [3:0] n_typed = USE_PREDICTOR,
                                            input logic [0:6][7:0] typed = '0);
        track_item_t it;
        it = '{kind, tick, ev, ch, d1, d2, n_typed, typed};
        return it;
    endfunction

    // Append one row to the directed table.
    task automatic add_row(input track_item_t row);
        directed_rows = {directed_rows, row};
    endtask

    // Present one word, hold it until taken, then queue its expected bytes.
    // Call at a rising edge; valid stays high for the caller to keep or drop.
    task automatic push_item(input track_item_t it);
        logic [0:6][7:0] frame;
        int              n;
        track_byte_t     nb;
        s_tvalid <= 1'b1;
        s_tdata  <= {it.data_second, it.data_first, it.channel, it.event_type, it.tick};
        s_tuser  <= it.kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n = encode_item(it, frame);
        // Typed-in rows override the predictor, which still tracks the tick.
        if (it.typed_count != USE_PREDICTOR) begin
            n     = it.typed_count;
            frame = it.typed_bytes;
        end
        for (int i = 0; i < n; i++) begin
            nb.value      = frame[i];
            nb.last       = (i == n - 1);
            pending_bytes = {pending_bytes, nb};
        end
        if (it.kind != REQ_UNUSED)
            items_accepted++;
    endtask

    // Drain, let the pipeline settle, then write the tempo.
    task automatic set_tempo(input logic [23:0] value);
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tempo_model = value;
        tempo_writes++;
    endtask

    // Mostly well-formed tracks (start, events, end) with random content,
    // plus backward ticks, ignored kinds and stray words.
    task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct,
                                    input bit hold_mid);
        int                sent;
        int                seq_left;
        bit                in_track;
        int                r;
        int                d;
        logic [TICK_W-1:0] gen_tick;
        logic [TICK_W-1:0] delta;
        logic [7:0]        ev;
        track_item_t       it;
        sent           = 0;
        seq_left       = 0;
        in_track       = 1'b0;
        gen_tick       = '0;
        sink_stall_pct = stall_pct;
        while (sent < n_items) begin
            r  = $urandom_range(99);
            ev = ($urandom_range(99) < 80) ? 8'($urandom_range(8, 14)) << 4
                                           : 8'($urandom_range(255));
            it = mk_item(REQ_EVENT, 28'($urandom), ev, 4'($urandom), 8'($urandom),
                         8'($urandom));
            if (!in_track) begin
                if (r < 90) begin
                    it.kind  = REQ_START;
                    in_track = 1'b1;
                    seq_left = $urandom_range(2, 10);
                    gen_tick = '0;
                end else begin
                    it.kind = 2'($urandom_range(3));
                end
            end else if (seq_left == 0) begin
                it.kind  = REQ_END;
                in_track = 1'b0;
            end else begin
                seq_left--;
                if (r < 88) begin
                    // Spread deltas over every VLQ length, short ones most often.
                    d = $urandom_range(99);
                    if (d < 45)
                        delta = 28'($urandom_range(127));
                    else if (d < 75)
                        delta = 28'($urandom_range(16383, 128));
                    else if (d < 92)
                        delta = 28'($urandom_range(2097151, 16384));
                    else
                        delta = 28'($urandom_range(268435455, 2097152));
                    it.tick = gen_tick + delta;
                end else if (r < 93) begin
                    it.tick = gen_tick - 28'($urandom_range(300, 1));
                end else if (r < 97) begin
                    it.kind = REQ_UNUSED;
                end
            end
            if (it.kind == REQ_EVENT)
                gen_tick = it.tick;
            while ($urandom_range(99) < idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            push_item(it);
            if (it.kind != REQ_UNUSED)
                sent++;
            if (hold_mid && sent == n_items / 2) begin
                // Hold the sender off until the output has fully drained.
                s_tvalid <= 1'b0;
                while (pending_bytes.size() != 0) @(posedge aclk);
                @(posedge aclk);
                hold_mid = 1'b0;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        // Reset tempo 500000 is 07 A1 20 on the wire.
        add_row(mk_item(REQ_START, 28'h0000123, 8'h00, 4'h0, 8'h00, 8'h00,
            4'd7, {8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20}));
        add_row(mk_item(REQ_EVENT, 28'd0, 8'h90, 4'h0, 8'h3C, 8'h64,
            4'd4, {8'h00, 8'h90, 8'h3C, 8'h64, 24'h0}));
        add_row(mk_item(REQ_EVENT, 28'd127, 8'h90, 4'h1, 8'h40, 8'h7F));
        add_row(mk_item(REQ_EVENT, 28'd255, 8'h80, 4'h2, 8'h40, 8'h00));
        add_row(mk_item(REQ_EVENT, 28'd16638, 8'hB0, 4'h7, 8'h07, 8'h64));
        add_row(mk_item(REQ_EVENT, 28'd33022, 8'hD0, 4'h8, 8'h7F, 8'h01));
        add_row(mk_item(REQ_START, 28'd0, 8'h00, 4'h0, 8'h00, 8'h00,
            4'd7, {8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20}));
        // Largest delta: four VLQ groups, all data bits set.
        add_row(mk_item(REQ_EVENT, 28'hFFFFFFF, 8'hF0, 4'hF, 8'hFF, 8'hFF,
            4'd7, {8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF}));
        // Time runs backwards: delta clamps to zero.
        add_row(mk_item(REQ_EVENT, 28'd5, 8'hE0, 4'h3, 8'h00, 8'h40,
            4'd4, {8'h00, 8'hE3, 8'h00, 8'h40, 24'h0}));
        add_row(mk_item(REQ_UNUSED, 28'hFFFFFFF, 8'hFF, 4'hF, 8'hFF, 8'hFF,
            4'd0));
        add_row(mk_item(REQ_EVENT, 28'd6, 8'hC0, 4'h9, 8'h05, 8'h00));
        add_row(mk_item(REQ_END, 28'hABCDEF0, 8'h12, 4'h3, 8'h45, 8'h67,
            4'd4, {8'h00, 8'hFF, 8'h2F, 8'h00, 24'h0}));
        // End leaves the tick alone, so the same tick gives a zero delta.
        add_row(mk_item(REQ_EVENT, 28'd6, 8'h00, 4'h0, 8'h00, 8'h00,
            4'd4, {8'h00, 8'h00, 8'h00, 8'h00, 24'h0}));
        add_row(mk_item(REQ_UNUSED, 28'd0, 8'h00, 4'h0, 8'h00, 8'h00, 4'd0));
        add_row(mk_item(REQ_EVENT, 28'h0200000, 8'hA0, 4'h5, 8'hAA, 8'h55));
        add_row(mk_item(REQ_EVENT, 28'h5555555, 8'h55, 4'hA, 8'h55, 8'hAA));
        add_row(mk_item(REQ_EVENT, 28'hAAAAAAA, 8'hAA, 4'h5, 8'hAA, 8'h55));
        add_row(mk_item(REQ_START, 28'hFFFFFFF, 8'hFF, 4'hF, 8'hFF, 8'hFF,
            4'd7, {8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20}));
        add_row(mk_item(REQ_END, 28'd0, 8'h00, 4'h0, 8'h00, 8'h00,
            4'd4, {8'h00, 8'hFF, 8'h2F, 8'h00, 24'h0}));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words back to back, sink always ready.
        sink_stall_pct = 0;
        foreach (directed_rows[i])
            push_item(directed_rows[i]);
        s_tvalid <= 1'b0;

        set_tempo(24'hFFFFFF);
        run_random_phase(PHASE_ITEMS, 0, 0, 1'b0);
        set_tempo(24'h000000);
        run_random_phase(PHASE_ITEMS, 77, 0, 1'b0);
        set_tempo(24'h000001);
        run_random_phase(PHASE_ITEMS, 0, 77, 1'b1);
        set_tempo(24'($urandom));
        run_random_phase(PHASE_ITEMS, 9, 9, 1'b0);
        set_tempo(TEMPO_RESET);
        run_random_phase(PHASE_ITEMS, 0, 0, 1'b0);

        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d track items and %0d output bytes over %0d tempo settings,",
                 items_accepted, bytes_checked, tempo_writes + 1);
        $display("with source gaps, sink stalls and a full drain mid-stream; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
rtl/mte_pkg.sv
rtl/mte_frame_build.sv
rtl/midi_track_event_encoder.sv
test/tb_midi_track_event_encoder.sv
